### hdl/rgbc_pkg.sv
// Shared types and constants for the RGB 3x3 normalized convolution block.
// No dependencies; imported by every module of the block except rgbc_line_mem.
`default_nettype none

package rgbc_pkg;

   // packed pixel: blue 23:16, green 15:8, red 7:0
   localparam int PIX_W  = 24;
   localparam int ROW_W  = 48;   // one coefficient row, left tap in 47:32
   localparam int SLOT_W = 16;   // one tap slot inside a coefficient row
   localparam int ACC_W  = 28;   // 9 * 255 * 2^15 fits signed 28 bits
   localparam int KSUM_W = 20;   // 9 * 2^15 fits signed 20 bits
   localparam int NUM_TAPS = 9;

   localparam logic [7:0] BYTE_MAX = 8'hFF;

   // configuration register indexes
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_COEF_TOP     = 3'd2;
   localparam logic [2:0] CSR_COEF_MIDDLE  = 3'd3;
   localparam logic [2:0] CSR_COEF_BOTTOM  = 3'd4;

   // reset values of the configuration registers
   localparam logic [10:0]      FRAME_WIDTH_RST  = 11'd640;
   localparam logic [12:0]      FRAME_HEIGHT_RST = 13'd480;
   localparam logic [ROW_W-1:0] COEF_TOP_RST     = 48'h0;
   localparam logic [ROW_W-1:0] COEF_MIDDLE_RST  = 48'h0000_0001_0000;
   localparam logic [ROW_W-1:0] COEF_BOTTOM_RST  = 48'h0;

   typedef logic [PIX_W-1:0] pixel_type;

   // sums of one window, channel 0 blue, 1 green, 2 red
   typedef struct packed {
      logic [2:0][ACC_W-1:0] acc;
      logic [KSUM_W-1:0]     ksum;
   } sums_type;

   // job handed from the control to the divider
   typedef struct packed {
      logic     start;
      logic     last;
      sums_type sums;
   } div_job_type;

endpackage

`default_nettype wire

### hdl/rgb_conv3x3_normalized.sv
// Top level of the RGB 3x3 normalized convolution: control, window, counters.
// Depends on rgbc_pkg, rgbc_line_mem, rgbc_mac and rgbc_div.
//
//  channel | direction | transfer when          | payload
//  req_    | in        | req_tvalid & tready    | tuser operation, tdata r/g/b
//  rsp_    | out       | rsp_tvalid & tready    | tdata r/g/b out, tlast end
//  csr_    | in        | csr_wen high           | csr_addr index, csr_wdata
//
// An item with no result passes through accept and the line store read-modify-write.
// An item with a result passes through read, the tap walk and the hand-off to
// the divider queue. The bit-serial divider takes no new job until its result
// has left the output register, so it holds at most one result at a time.
// Reset is synchronous; the line store has no reset and needs no clearing.
// A stalled output holds one result while the next item is taken in.
`default_nettype none

module rgb_conv3x3_normalized #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int COEF_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red, green, blue
   input  wire logic        req_tuser,   // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // red_out, green_out, blue_out
   output logic             rsp_tlast,   // last_of_frame
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [47:0] csr_wdata
);
   import rgbc_pkg::*;

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int WW       = $clog2(MAX_WIDTH + 1);
   localparam int HW       = $clog2(MAX_HEIGHT + 2);
   localparam int TAP_BITS = (COEF_BITS < 16) ? COEF_BITS : 16;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_MAC   = 2'd2;
   localparam logic [1:0] ST_QUEUE = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [10:0]             fw_ff, fw_in;
   logic [12:0]             fh_ff, fh_in;
   logic [2:0][ROW_W-1:0]   coef_ff, coef_in;
   pixel_type [NUM_TAPS-1:0] win_ff, win_in;
   pixel_type               px_ff, px_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in;
   logic [HW-1:0]           in_row_ff, in_row_in;
   logic [COL_W-1:0]        out_col_ff, out_col_in;
   logic [HW-1:0]           out_row_ff, out_row_in;
   logic [NUM_TAPS-1:0]     mask_ff, mask_in;
   logic                    last_ff, last_in;

   logic [WW-1:0]      eff_w;
   logic [HW-1:0]      eff_h;
   logic               accept, drain, left;
   logic               rd_en, wr_en, mac_start, mac_done, div_free, div_start;
   logic [2*PIX_W-1:0] rd_data, wr_data;
   logic [WW-1:0]      col_inc, ocol_inc;
   logic [HW-1:0]      orow_inc;
   logic               emit;
   logic [2:0]         row_ok, col_ok;
   sums_type           sums;
   div_job_type        job;

   // effective frame size: zero acts as one, large values saturate
   always_comb begin
      if (fw_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(fw_ff);
      end
      if (fh_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(fh_ff) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(fh_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign drain      = req_tuser;
   assign left       = in_row_ff < eff_h;
   assign col_inc    = WW'(in_col_ff) + WW'(1);
   assign ocol_inc   = WW'(out_col_ff) + WW'(1);
   assign orow_inc   = out_row_ff + HW'(1);
   assign emit       = (in_row_ff >= HW'(2)) || (in_row_ff == HW'(1) && in_col_ff != '0);
   assign wr_data    = {rd_data[PIX_W-1:0], px_ff};

   // neighborhood positions inside the frame
   assign row_ok = {orow_inc < eff_h, 1'b1, out_row_ff != '0};
   assign col_ok = {ocol_inc < eff_w, 1'b1, out_col_ff != '0};

   // control sequencer
   always_comb begin
      state_in   = state_ff;
      fw_in      = fw_ff;
      fh_in      = fh_ff;
      coef_in    = coef_ff;
      win_in     = win_ff;
      px_in      = px_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      mask_in    = mask_ff;
      last_in    = last_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      mac_start  = 1'b0;
      div_start  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // drain beats are dropped while frame pixels are still due
            if (accept && !(drain && left)) begin
               px_in    = (!drain && left) ?
                          {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]} : '0;
               rd_en    = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            for (int r = 0; r < 3; r++) begin
               win_in[r*3]     = win_ff[r*3 + 1];
               win_in[r*3 + 1] = win_ff[r*3 + 2];
            end
            win_in[2] = rd_data[2*PIX_W-1:PIX_W];
            win_in[5] = rd_data[PIX_W-1:0];
            win_in[8] = px_ff;
            wr_en     = 1'b1;
            if (col_inc >= eff_w) begin
               in_col_in = '0;
               in_row_in = in_row_ff + HW'(1);
            end else begin
               in_col_in = COL_W'(col_inc);
            end
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  mask_in[r*3 + c] = row_ok[r] && col_ok[c];
               end
            end
            last_in = (orow_inc >= eff_h) && (ocol_inc >= eff_w);
            if (emit) begin
               mac_start = 1'b1;
               state_in  = ST_MAC;
            end else begin
               state_in  = ST_IDLE;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               state_in = ST_QUEUE;
            end
         end
         ST_QUEUE: begin
            // hand the sums to the divider, then step the output position
            if (div_free) begin
               div_start = 1'b1;
               state_in  = ST_IDLE;
               if (last_ff) begin
                  win_in     = '0;
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
                  out_row_in = '0;
               end else if (ocol_inc >= eff_w) begin
                  out_col_in = '0;
                  out_row_in = orow_inc;
               end else begin
                  out_col_in = COL_W'(ocol_inc);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // register writes; a frame size change restarts the frame
      if (csr_wen) begin
         case (csr_addr) inside
            CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT: begin
               if (csr_addr == CSR_FRAME_WIDTH) begin
                  fw_in = csr_wdata[10:0];
               end else begin
                  fh_in = csr_wdata[12:0];
               end
               win_in     = '0;
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
            CSR_COEF_TOP:    coef_in[0] = csr_wdata;
            CSR_COEF_MIDDLE: coef_in[1] = csr_wdata;
            CSR_COEF_BOTTOM: coef_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   assign job = {div_start, last_ff, sums};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fw_ff      <= FRAME_WIDTH_RST;
         fh_ff      <= FRAME_HEIGHT_RST;
         coef_ff    <= {COEF_BOTTOM_RST, COEF_MIDDLE_RST, COEF_TOP_RST};
         win_ff     <= '0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         coef_ff    <= coef_in;
         win_ff     <= win_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      mask_ff <= mask_in;
      last_ff <= last_in;
   end

   rgbc_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W),
      .DW    (2*PIX_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (in_col_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (in_col_ff),
      .wr_data (wr_data)
   );

   rgbc_mac #(
      .TAP_BITS (TAP_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .mask  (mask_ff),
      .win   (win_ff),
      .coef  (coef_ff),
      .done  (mac_done),
      .sums  (sums)
   );

   rgbc_div u_div (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .free       (div_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // tap sums finish only while the sequencer waits for them
   a_mac_done_state: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_MAC)
      else $error("tap sums finished outside the wait state");

   // input column stays inside the effective row width
   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      WW'(in_col_ff) < eff_w)
      else $error("input column beyond frame width");

   // output position never runs ahead of the input position
   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= in_row_ff)
      else $error("output row ahead of input row");
`endif

endmodule

`default_nettype wire

### hdl/rgbc_line_mem.sv
// Line store: one synchronous RAM holding the upper and middle line per column.
// One write port, one read port, registered read data. Uses no package.
`default_nettype none

module rgbc_line_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 48
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/rgbc_mac.sv
// Tap sequencer: walks the nine window taps, one per cycle, building the
// three channel sums and the kernel sum. Depends on rgbc_pkg.
`default_nettype none

module rgbc_mac #(
   parameter int TAP_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [rgbc_pkg::NUM_TAPS-1:0]      mask,
   input  wire rgbc_pkg::pixel_type [rgbc_pkg::NUM_TAPS-1:0] win,
   input  wire logic [2:0][rgbc_pkg::ROW_W-1:0]    coef,
   output logic                                    done,
   output rgbc_pkg::sums_type                      sums
);
   import rgbc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [3:0]        k_ff, k_in;
   logic [1:0]        row_ff, row_in;
   logic [1:0]        col_ff, col_in;
   logic [2:0][ACC_W-1:0] acc_ff, acc_in;
   logic [KSUM_W-1:0] ksum_ff, ksum_in;

   logic [SLOT_W-1:0]        raw;
   logic signed [SLOT_W-1:0] tap;
   pixel_type                pix;
   logic signed [24:0]       prod [3];

   // tap slot of the current kernel position
   always_comb begin
      case (col_ff)
         2'd0:    raw = coef[row_ff][47:32];
         2'd1:    raw = coef[row_ff][31:16];
         default: raw = coef[row_ff][15:0];
      endcase
      tap = SLOT_W'(signed'(raw[TAP_BITS-1:0]));
      pix = mask[k_ff] ? win[k_ff] : '0;
      prod[0] = $signed({1'b0, pix[23:16]}) * tap;
      prod[1] = $signed({1'b0, pix[15:8]}) * tap;
      prod[2] = $signed({1'b0, pix[7:0]}) * tap;
   end

   // sequencer
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      acc_in  = acc_ff;
      ksum_in = ksum_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = '0;
         row_in  = '0;
         col_in  = '0;
         acc_in  = '0;
         ksum_in = '0;
      end else if (busy_ff) begin
         for (int c = 0; c < 3; c++) begin
            acc_in[c] = ACC_W'($signed(acc_ff[c]) + ACC_W'(prod[c]));
         end
         ksum_in = KSUM_W'($signed(ksum_ff) + KSUM_W'(tap));
         if (k_ff == 4'(NUM_TAPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff + 4'd1;
            if (col_ff == 2'd2) begin
               col_in = '0;
               row_in = row_ff + 2'd1;
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      acc_ff  <= acc_in;
      ksum_ff <= ksum_in;
   end

   assign done = done_ff;
   assign sums = {acc_ff, ksum_ff};

endmodule

`default_nettype wire

### hdl/rgbc_div.sv
// Bit-serial divider for the three channel sums by the kernel sum, with
// clamp to 0..255 and the result output register. Depends on rgbc_pkg.
`default_nettype none

module rgbc_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rgbc_pkg::div_job_type job,
   output logic                       free,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [23:0]                rsp_tdata,   // red_out, green_out, blue_out
   output logic                       rsp_tlast    // last_of_frame
);
   import rgbc_pkg::*;

   localparam int CNT_W = $clog2(ACC_W);

   logic                  busy_ff, busy_in;
   logic                  oval_ff, oval_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [2:0][ACC_W-1:0] dvd_ff, dvd_in;
   logic [2:0][KSUM_W-1:0] rem_ff, rem_in;
   logic [KSUM_W-1:0]     dmag_ff, dmag_in;
   logic [2:0]            neg_ff, neg_in;
   logic                  last_ff, last_in;
   logic [2:0][7:0]       res_ff, res_in;
   logic                  olast_ff, olast_in;

   logic signed [KSUM_W-1:0] dsor;
   logic signed [ACC_W-1:0]  a_s;
   logic [KSUM_W-1:0]        trial;
   logic                     ge;

   always_comb begin
      busy_in  = busy_ff;
      oval_in  = oval_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dmag_in  = dmag_ff;
      neg_in   = neg_ff;
      last_in  = last_ff;
      res_in   = res_ff;
      olast_in = olast_ff;
      dsor     = '0;
      a_s      = '0;
      trial    = '0;
      ge       = 1'b0;

      // result register empties on a transfer
      if (oval_ff && rsp_tready) begin
         oval_in = 1'b0;
      end

      if (job.start) begin
         // zero kernel sum divides by one
         dsor = (job.sums.ksum == '0) ? KSUM_W'(1) : $signed(job.sums.ksum);
         dmag_in = dsor[KSUM_W-1] ? KSUM_W'(-dsor) : dsor;
         for (int c = 0; c < 3; c++) begin
            a_s       = $signed(job.sums.acc[c]);
            neg_in[c] = a_s[ACC_W-1] ^ dsor[KSUM_W-1];
            dvd_in[c] = a_s[ACC_W-1] ? ACC_W'(-a_s) : a_s;
         end
         rem_in  = '0;
         cnt_in  = '0;
         last_in = job.last;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one restoring step per channel
         for (int c = 0; c < 3; c++) begin
            trial     = {rem_ff[c][KSUM_W-2:0], dvd_ff[c][ACC_W-1]};
            ge        = trial >= dmag_ff;
            rem_in[c] = ge ? trial - dmag_ff : trial;
            dvd_in[c] = {dvd_ff[c][ACC_W-2:0], ge};
         end
         if (cnt_ff == CNT_W'(ACC_W - 1)) begin
            busy_in  = 1'b0;
            oval_in  = 1'b1;
            olast_in = last_ff;
            // negative quotient clamps to zero, large ones to full scale
            for (int c = 0; c < 3; c++) begin
               if (neg_ff[c]) begin
                  res_in[c] = '0;
               end else if (dvd_in[c] > ACC_W'(BYTE_MAX)) begin
                  res_in[c] = BYTE_MAX;
               end else begin
                  res_in[c] = dvd_in[c][7:0];
               end
            end
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         oval_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         oval_ff <= oval_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dmag_ff  <= dmag_in;
      neg_ff   <= neg_in;
      last_ff  <= last_in;
      res_ff   <= res_in;
      olast_ff <= olast_in;
   end

   assign free       = !busy_ff && !oval_ff;
   assign rsp_tvalid = oval_ff;
   assign rsp_tdata  = {res_ff[2], res_ff[1], res_ff[0]};
   assign rsp_tlast  = olast_ff;

endmodule

`default_nettype wire
